>>> src/bdch_pkg.sv
// ----------------------------------------------------------------------------
// bdch_pkg
// Shared types and constants of the button debouncer with click and hold
// detection: field widths, register indexes, reset values and structs.
// ----------------------------------------------------------------------------
package bdch_pkg;

    // fixed field widths
    localparam int TIME_W    = 32;
    localparam int CFG_W     = 16;
    localparam int CFG_IDX_W = 2;

    // register indexes of the configuration port
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_IDLE_HIGH    = 2'd0,
        REG_SETTLE_TICKS = 2'd1,
        REG_CLICK_WINDOW = 2'd2,
        REG_HOLD_TICKS   = 2'd3
    } cfg_index_t;

    // reset values of the timing registers
    localparam logic [CFG_W-1:0] SETTLE_TICKS_RST = 16'd50;
    localparam logic [CFG_W-1:0] CLICK_WINDOW_RST = 16'd500;
    localparam logic [CFG_W-1:0] HOLD_TICKS_RST   = 16'd2000;

    // configuration seen by the core
    typedef struct packed {
        logic             idle_high;
        logic [CFG_W-1:0] settle_ticks;
        logic [CFG_W-1:0] click_window;
        logic [CFG_W-1:0] hold_ticks;
    } cfg_t;

    // one result beat
    typedef struct packed {
        logic pressed;
        logic press_event;
        logic release_event;
        logic click_event;
        logic hold_event;
    } result_t;

endpackage

>>> src/button_debounce_click_hold.sv
// ----------------------------------------------------------------------------
// button_debounce_click_hold
// Button debouncer with press, release, click and hold events per scan sample.
// ----------------------------------------------------------------------------
// Each input beat is one scan sample (pin level and tick time) and yields
// exactly one result beat. A sample is taken every cycle unless m_ready stalls
// the result channel: an input register feeds the single-pass debounce logic,
// whose result lands in an output register, so throughput is one beat per cycle
// while m_ready keeps up. The output register lets a new sample enter
// while a result waits for m_ready. Deadlines are TICK_BITS+1 bits wide and
// tick wrap is not handled. Write configuration only while the block is idle.
module button_debounce_click_hold #(
    parameter int TICK_BITS = 32
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    // sample channel
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic                          s_pin_level,
    input  logic [bdch_pkg::TIME_W-1:0]    s_time_now,
    // result channel
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic                          m_pressed,
    output logic                          m_press_event,
    output logic                          m_release_event,
    output logic                          m_click_event,
    output logic                          m_hold_event,
    // configuration write port
    input  logic                          cfg_wr_en,
    input  logic [bdch_pkg::CFG_IDX_W-1:0] cfg_wr_index,
    input  logic [bdch_pkg::CFG_W-1:0]     cfg_wr_data
);
    import bdch_pkg::*;

    cfg_t    cfg;
    result_t result;

    logic              in_valid_reg, in_valid_next;
    logic              in_level_reg;
    logic [TIME_W-1:0] in_time_reg;
    logic              out_valid_reg, out_valid_next;
    result_t           out_reg;
    logic              advance;

    // a beat moves on when the output register is free or being drained
    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_valid && s_ready) begin
            in_valid_next = 1'b1;
        end else if (advance) begin
            in_valid_next = 1'b0;
        end
    end

    always_comb begin
        out_valid_next = out_valid_reg;
        if (advance) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // input sample register
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_level_reg <= s_pin_level;
            in_time_reg  <= s_time_now;
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (advance) begin
            out_reg <= result;
        end
    end

    bdch_cfg u_cfg (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_index (cfg_wr_index),
        .cfg_wr_data  (cfg_wr_data),
        .cfg          (cfg)
    );

    bdch_core #(
        .TICK_BITS (TICK_BITS)
    ) u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .step_en   (advance),
        .pin_level (in_level_reg),
        .time_now  (in_time_reg),
        .cfg       (cfg),
        .result    (result)
    );

    assign m_valid         = out_valid_reg;
    assign m_pressed       = out_reg.pressed;
    assign m_press_event   = out_reg.press_event;
    assign m_release_event = out_reg.release_event;
    assign m_click_event   = out_reg.click_event;
    assign m_hold_event    = out_reg.hold_event;

endmodule

>>> src/bdch_cfg.sv
// ----------------------------------------------------------------------------
// bdch_cfg
// Configuration register file: idle level, debounce, click and hold times.
// ----------------------------------------------------------------------------
module bdch_cfg (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_wr_en,
    input  logic [bdch_pkg::CFG_IDX_W-1:0] cfg_wr_index,
    input  logic [bdch_pkg::CFG_W-1:0]     cfg_wr_data,
    output bdch_pkg::cfg_t                cfg
);
    import bdch_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    // register write decode
    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wr_en) begin
            unique case (cfg_index_t'(cfg_wr_index))
                REG_IDLE_HIGH:    cfg_next.idle_high    = cfg_wr_data[0];
                REG_SETTLE_TICKS: cfg_next.settle_ticks = cfg_wr_data;
                REG_CLICK_WINDOW: cfg_next.click_window = cfg_wr_data;
                REG_HOLD_TICKS:   cfg_next.hold_ticks   = cfg_wr_data;
                default:          cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.idle_high    <= 1'b0;
            cfg_reg.settle_ticks <= SETTLE_TICKS_RST;
            cfg_reg.click_window <= CLICK_WINDOW_RST;
            cfg_reg.hold_ticks   <= HOLD_TICKS_RST;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

>>> src/bdch_core.sv
// ----------------------------------------------------------------------------
// bdch_core
// Debounce state and event logic: takes one sample per step, updates the
// accepted level and the deadlines, and produces the result beat.
// ----------------------------------------------------------------------------
module bdch_core #(
    parameter int TICK_BITS = 32
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        step_en,
    input  logic                        pin_level,
    input  logic [bdch_pkg::TIME_W-1:0] time_now,
    input  bdch_pkg::cfg_t              cfg,
    output bdch_pkg::result_t           result
);
    import bdch_pkg::*;

    localparam int DL_W = TICK_BITS + 1;

    logic            accepted_level_reg, accepted_level_next;
    logic            hold_reported_reg,  hold_reported_next;
    logic [DL_W-1:0] debounce_deadline_reg, debounce_deadline_next;
    logic [DL_W-1:0] click_deadline_reg,    click_deadline_next;
    logic [DL_W-1:0] hold_deadline_reg,     hold_deadline_next;

    logic                 level;
    logic [TICK_BITS-1:0] now_tick;
    logic [DL_W-1:0]      now_ext;
    logic [DL_W-1:0]      debounce_after;
    logic [DL_W-1:0]      click_after;
    logic [DL_W-1:0]      hold_after;
    logic                 press_ev, release_ev, click_ev, hold_ev;

    // sample level and time in the deadline domain
    assign level          = pin_level ^ cfg.idle_high;
    assign now_tick       = TICK_BITS'(time_now);
    assign now_ext        = DL_W'(now_tick);
    assign debounce_after = now_ext + DL_W'(cfg.settle_ticks);
    assign click_after    = now_ext + DL_W'(cfg.click_window);
    assign hold_after     = now_ext + DL_W'(cfg.hold_ticks);

    // accept decision, then the hold check on the updated state
    always_comb begin
        accepted_level_next    = accepted_level_reg;
        hold_reported_next     = hold_reported_reg;
        debounce_deadline_next = debounce_deadline_reg;
        click_deadline_next    = click_deadline_reg;
        hold_deadline_next     = hold_deadline_reg;
        press_ev   = 1'b0;
        release_ev = 1'b0;
        click_ev   = 1'b0;
        hold_ev    = 1'b0;
        if (level != accepted_level_reg) begin
            if (now_ext >= debounce_deadline_reg) begin
                accepted_level_next = level;
                if (level) begin
                    click_deadline_next = click_after;
                    hold_deadline_next  = hold_after;
                    hold_reported_next  = 1'b0;
                    press_ev            = 1'b1;
                end else begin
                    release_ev = 1'b1;
                    click_ev   = (now_ext < click_deadline_reg);
                end
            end
        end else begin
            debounce_deadline_next = debounce_after;
        end
        if (accepted_level_next && !hold_reported_next &&
            (now_ext >= hold_deadline_next)) begin
            hold_reported_next = 1'b1;
            hold_ev            = 1'b1;
        end
    end

    // state update, one step per sample
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            accepted_level_reg    <= 1'b0;
            hold_reported_reg     <= 1'b0;
            debounce_deadline_reg <= '0;
            click_deadline_reg    <= '0;
            hold_deadline_reg     <= '0;
        end else if (step_en) begin
            accepted_level_reg    <= accepted_level_next;
            hold_reported_reg     <= hold_reported_next;
            debounce_deadline_reg <= debounce_deadline_next;
            click_deadline_reg    <= click_deadline_next;
            hold_deadline_reg     <= hold_deadline_next;
        end
    end

    assign result.pressed       = accepted_level_next;
    assign result.press_event   = press_ev;
    assign result.release_event = release_ev;
    assign result.click_event   = click_ev;
    assign result.hold_event    = hold_ev;

    // checks
    a_click_with_release: assert property (@(posedge aclk) disable iff (!aresetn)
        step_en && result.click_event |-> result.release_event)
        else $error("click without release");

    a_press_release_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        step_en |-> !(result.press_event && result.release_event))
        else $error("press and release in one beat");

    a_hold_while_pressed: assert property (@(posedge aclk) disable iff (!aresetn)
        step_en && result.hold_event |-> result.pressed)
        else $error("hold while released");

    a_hold_marked: assert property (@(posedge aclk) disable iff (!aresetn)
        step_en && result.hold_event |=> hold_reported_reg)
        else $error("hold not marked as reported");

    a_edge_updates_level: assert property (@(posedge aclk) disable iff (!aresetn)
        step_en && (result.press_event || result.release_event)
        |=> accepted_level_reg == $past(result.press_event))
        else $error("accepted level does not follow event");

endmodule
